@@ sv/pmv_pkg.sv @@
`timescale 1ns / 1ps

package pmv_pkg;

    localparam int unsigned SIG_LEN      = 5;
    localparam int unsigned HDR_BYTES    = 25;
    localparam int unsigned ENTRY_BYTES  = 17;
    localparam logic [7:0]  KIND_MAX     = 8'd1;

    localparam logic [2:0] STATUS_ENTRY_OK     = 3'd0;
    localparam logic [2:0] STATUS_EMPTY_OK     = 3'd1;
    localparam logic [2:0] STATUS_BAD_IDENT    = 3'd2;
    localparam logic [2:0] STATUS_HDR_MISMATCH = 3'd3;
    localparam logic [2:0] STATUS_BAD_ENTRY    = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        last;
        logic [31:0] entry_index;
        logic        payload_kind;
        logic [63:0] payload_offset;
        logic [63:0] payload_size;
    } result_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'h4B;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h4C;
            3'd3:    b = 8'h44;
            3'd4:    b = 8'h30;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ sv/payload_manifest_validator.sv @@
`timescale 1ns / 1ps

// Validates a manifest that arrives one byte per transaction and accepts a new byte every
// clock cycle unless a held byte waits on a stalled result register. Each byte passes an
// input register, is parsed once the result register is free and leaves its result, if
// any, there; the parser advances one byte per cycle while the result register is free.
// A byte with start_req high restarts parsing; while idle, other bytes are dropped. Every
// result with last high returns the block to idle. The user must write the byte order
// register through cfg_we and cfg_wdata only while no transaction is held inside the
// block, which does not enforce it; each byte uses the byte order in force when parsed.

module payload_manifest_validator
    import pmv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        last,
    output logic [31:0] entry_index,
    output logic        payload_kind,
    output logic [63:0] payload_offset,
    output logic [63:0] payload_size
);

    logic     big_endian_reg;
    in_item_t in_item;
    in_item_t item;
    logic     proc_en;
    logic     out_free;
    logic     res_valid;
    result_t  res;
    result_t  out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            big_endian_reg <= cfg_wdata;
        end
    end

    assign in_item.data_byte = data_byte;
    assign in_item.start_req = start_req;

    pmv_in_stage u_in_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_item         (in_item),
        .downstream_free (out_free),
        .proc_en         (proc_en),
        .item            (item)
    );

    pmv_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .proc_en    (proc_en),
        .item       (item),
        .big_endian (big_endian_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    pmv_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc_en && res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (out_free),
        .out_res   (out_res)
    );

    assign status         = out_res.status;
    assign last           = out_res.last;
    assign entry_index    = out_res.entry_index;
    assign payload_kind   = out_res.payload_kind;
    assign payload_offset = out_res.payload_offset;
    assign payload_size   = out_res.payload_size;

    // Every status other than an accepted entry ends the manifest.
    a_final_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_ENTRY_OK |-> last)
        else $error("non-entry status without last");

    a_kind_only_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_ENTRY_OK |-> !payload_kind)
        else $error("payload_kind set on a non-entry status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_ENTRY_OK || status == STATUS_EMPTY_OK ||
                      status == STATUS_BAD_IDENT || status == STATUS_HDR_MISMATCH ||
                      status == STATUS_BAD_ENTRY)
        else $error("status code out of range");

    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !in_ready |=> !$changed(status))
        else $error("result changed while stalled and input blocked");

endmodule

@@ sv/pmv_in_stage.sv @@
`timescale 1ns / 1ps

module pmv_in_stage
    import pmv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     downstream_free,
    output logic     proc_en,
    output in_item_t item
);

    logic     full_reg;
    logic     full_next;
    in_item_t item_reg;

    // The held transaction is processed whenever the result register can take a result.
    assign proc_en   = full_reg && downstream_free;
    assign in_ready  = !full_reg || downstream_free;
    assign full_next = (in_valid && in_ready) || (full_reg && !proc_en);
    assign item      = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ sv/pmv_parser.sv @@
`timescale 1ns / 1ps

module pmv_parser
    import pmv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     proc_en,
    input  in_item_t item,
    input  logic     big_endian,
    output logic     res_valid,
    output result_t  res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_IDENT,
        PH_MSIZE,
        PH_BSIZE,
        PH_COUNT,
        PH_KIND,
        PH_OFFSET,
        PH_ESIZE
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [2:0]  pos_reg, pos_next, pos_cur;
    logic [63:0] acc_reg, acc_next, acc_cur;
    logic [63:0] manifest_reg, manifest_next;
    logic [63:0] bundle_reg, bundle_next;
    logic [31:0] expected_reg, expected_next;
    logic [31:0] seen_reg, seen_next;
    logic [7:0]  kind_reg, kind_next;
    logic [63:0] offset_reg, offset_next;
    logic [63:0] room_reg, room_next;
    logic        offset_bad_reg, offset_bad_next;

    logic [7:0]  b;
    logic [63:0] acc_le;
    logic [63:0] acc_new;
    logic        word_done;
    logic        count_done;
    logic [31:0] count_val;
    logic [36:0] count_x17;
    logic [64:0] meta_sum;
    logic        entry_bad;
    logic [31:0] seen_inc;

    assign b         = item.data_byte;
    assign phase_cur = item.start_req ? PH_IDENT : phase_reg;
    assign pos_cur   = item.start_req ? 3'd0 : pos_reg;
    assign acc_cur   = item.start_req ? 64'd0 : acc_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            acc_le[8*i +: 8] = (pos_cur == 3'(i)) ? (acc_cur[8*i +: 8] | b)
                                                  : acc_cur[8*i +: 8];
        end
    end

    assign acc_new    = big_endian ? {acc_cur[55:0], b} : acc_le;
    assign word_done  = (pos_cur == 3'd7);
    assign count_done = (pos_cur == 3'd3);
    assign count_val  = acc_new[31:0];
    assign count_x17  = {1'b0, count_val, 4'b0000} + {5'b00000, count_val};
    assign meta_sum   = {1'b0, bundle_reg} + 65'(HDR_BYTES) + {28'd0, count_x17};
    assign entry_bad  = (kind_reg > KIND_MAX) || offset_bad_reg || (acc_new > room_reg);
    assign seen_inc   = seen_reg + 32'd1;

    always_comb
    begin
        phase_next      = phase_cur;
        pos_next        = pos_cur;
        acc_next        = acc_cur;
        manifest_next   = manifest_reg;
        bundle_next     = bundle_reg;
        expected_next   = expected_reg;
        seen_next       = item.start_req ? 32'd0 : seen_reg;
        kind_next       = kind_reg;
        offset_next     = offset_reg;
        room_next       = room_reg;
        offset_bad_next = offset_bad_reg;
        res_valid       = 1'b0;
        res             = '0;

        case (phase_cur)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_IDENT:
            begin
                if (pos_cur > 3'(SIG_LEN - 1) || b != sig_byte(pos_cur))
                begin
                    res_valid  = 1'b1;
                    res.status = STATUS_BAD_IDENT;
                    res.last   = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (pos_cur == 3'(SIG_LEN - 1))
                begin
                    pos_next   = 3'd0;
                    acc_next   = 64'd0;
                    phase_next = PH_MSIZE;
                end
                else
                begin
                    pos_next = pos_cur + 3'd1;
                end
            end
            PH_MSIZE, PH_BSIZE, PH_OFFSET:
            begin
                if (word_done)
                begin
                    pos_next = 3'd0;
                    acc_next = 64'd0;
                    if (phase_cur == PH_MSIZE)
                    begin
                        manifest_next = acc_new;
                        phase_next    = PH_BSIZE;
                    end
                    else if (phase_cur == PH_BSIZE)
                    begin
                        bundle_next = acc_new;
                        phase_next  = PH_COUNT;
                    end
                    else
                    begin
                        offset_next     = acc_new;
                        offset_bad_next = acc_new > bundle_reg;
                        room_next       = bundle_reg - acc_new;
                        phase_next      = PH_ESIZE;
                    end
                end
                else
                begin
                    pos_next = pos_cur + 3'd1;
                    acc_next = acc_new;
                end
            end
            PH_COUNT:
            begin
                if (count_done)
                begin
                    pos_next      = 3'd0;
                    acc_next      = 64'd0;
                    expected_next = count_val;
                    if ({1'b0, manifest_reg} != meta_sum)
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_HDR_MISMATCH;
                        res.last   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else if (count_val == 32'd0)
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_EMPTY_OK;
                        res.last   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        seen_next  = 32'd0;
                        phase_next = PH_KIND;
                    end
                end
                else
                begin
                    pos_next = pos_cur + 3'd1;
                    acc_next = acc_new;
                end
            end
            PH_KIND:
            begin
                kind_next  = b;
                pos_next   = 3'd0;
                acc_next   = 64'd0;
                phase_next = PH_OFFSET;
            end
            PH_ESIZE:
            begin
                if (word_done)
                begin
                    pos_next           = 3'd0;
                    acc_next           = 64'd0;
                    res_valid          = 1'b1;
                    res.entry_index    = seen_reg;
                    res.payload_offset = offset_reg;
                    res.payload_size   = acc_new;
                    if (entry_bad)
                    begin
                        res.status = STATUS_BAD_ENTRY;
                        res.last   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res.status       = STATUS_ENTRY_OK;
                        res.payload_kind = kind_reg[0];
                        res.last         = (seen_inc == expected_reg);
                        seen_next        = seen_inc;
                        phase_next       = (seen_inc == expected_reg) ? PH_IDLE : PH_KIND;
                    end
                end
                else
                begin
                    pos_next = pos_cur + 3'd1;
                    acc_next = acc_new;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pos_reg        <= 3'd0;
            acc_reg        <= 64'd0;
            manifest_reg   <= 64'd0;
            bundle_reg     <= 64'd0;
            expected_reg   <= 32'd0;
            seen_reg       <= 32'd0;
            kind_reg       <= 8'd0;
            offset_reg     <= 64'd0;
            room_reg       <= 64'd0;
            offset_bad_reg <= 1'b0;
        end
        else if (proc_en)
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            acc_reg        <= acc_next;
            manifest_reg   <= manifest_next;
            bundle_reg     <= bundle_next;
            expected_reg   <= expected_next;
            seen_reg       <= seen_next;
            kind_reg       <= kind_next;
            offset_reg     <= offset_next;
            room_reg       <= room_next;
            offset_bad_reg <= offset_bad_next;
        end
    end

endmodule

@@ sv/pmv_out_stage.sv @@
`timescale 1ns / 1ps

module pmv_out_stage
    import pmv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    free,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pmv_pkg::*;

    localparam int          PHASE_BYTES  = 170;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          STALL_LIMIT  = 2000;
    localparam logic [39:0] SIG_WORD     = 40'h4B_41_4C_44_30;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0]
    {
        PP_IDLE,
        PP_SIG,
        PP_MSIZE,
        PP_BSIZE,
        PP_COUNT,
        PP_KIND,
        PP_OFFSET,
        PP_ESIZE
    } parse_phase_t;

    typedef struct packed
    {
        logic [7:0] b;
        logic       first;
    } stim_t;

    function automatic logic [7:0] sig_at(int unsigned pos);
        return SIG_WORD[8 * (4 - pos) +: 8];
    endfunction

    class manifest_scoreboard;
        result_t      expected_q[$];
        int           errors = 0;
        logic         big_endian = 1'b0;
        parse_phase_t phase = PP_IDLE;
        logic [3:0]   byte_pos = '0;
        logic [63:0]  acc = '0;
        logic [63:0]  manifest_len = '0;
        logic [63:0]  bundle_len = '0;
        logic [63:0]  cur_offset = '0;
        logic [31:0]  entries_total = '0;
        logic [31:0]  entries_done = '0;
        logic [7:0]   kind_byte = '0;

        function void expect_result(logic [2:0] st, logic lst, logic [31:0] idx, logic kind,
                                    logic [63:0] off, logic [63:0] sz);
            result_t r;
            r.status         = st;
            r.last           = lst;
            r.entry_index    = idx;
            r.payload_kind   = kind;
            r.payload_offset = off;
            r.payload_size   = sz;
            expected_q = {expected_q, r};
            if (lst)
            begin
                phase = PP_IDLE;
            end
        endfunction

        function bit shift_in(logic [7:0] b, int unsigned nbytes);
            int unsigned pos;
            pos = byte_pos[2:0];
            if (big_endian)
            begin
                acc = {acc[55:0], b};
            end
            else
            begin
                acc = acc | (64'(b) << (8 * pos));
            end
            pos++;
            if (pos >= nbytes)
            begin
                byte_pos = '0;
                return 1'b1;
            end
            byte_pos = pos[3:0];
            return 1'b0;
        endfunction

        // Called for every accepted input transaction.
        function void note_byte(logic [7:0] b, logic first);
            logic [63:0] meta;
            logic [63:0] sz;
            logic [31:0] idx;
            if (first)
            begin
                phase         = PP_SIG;
                byte_pos      = '0;
                acc           = '0;
                manifest_len  = '0;
                bundle_len    = '0;
                entries_total = '0;
                entries_done  = '0;
                kind_byte     = '0;
                cur_offset    = '0;
            end
            case (phase)
                PP_SIG:
                begin
                    if (byte_pos > 4 || b != sig_at(byte_pos))
                    begin
                        expect_result(STATUS_BAD_IDENT, 1'b1, '0, 1'b0, '0, '0);
                    end
                    else if (byte_pos == 4)
                    begin
                        byte_pos = '0;
                        acc      = '0;
                        phase    = PP_MSIZE;
                    end
                    else
                    begin
                        byte_pos++;
                    end
                end
                PP_MSIZE:
                begin
                    if (shift_in(b, 8))
                    begin
                        manifest_len = acc;
                        acc          = '0;
                        phase        = PP_BSIZE;
                    end
                end
                PP_BSIZE:
                begin
                    if (shift_in(b, 8))
                    begin
                        bundle_len = acc;
                        acc        = '0;
                        phase      = PP_COUNT;
                    end
                end
                PP_COUNT:
                begin
                    if (shift_in(b, 4))
                    begin
                        entries_total = acc[31:0];
                        acc           = '0;
                        meta = 64'(HDR_BYTES) + 64'(ENTRY_BYTES) * 64'(entries_total);
                        if (manifest_len < meta || manifest_len - meta != bundle_len)
                        begin
                            expect_result(STATUS_HDR_MISMATCH, 1'b1, '0, 1'b0, '0, '0);
                        end
                        else if (entries_total == 0)
                        begin
                            expect_result(STATUS_EMPTY_OK, 1'b1, '0, 1'b0, '0, '0);
                        end
                        else
                        begin
                            entries_done = '0;
                            phase        = PP_KIND;
                        end
                    end
                end
                PP_KIND:
                begin
                    kind_byte = b;
                    byte_pos  = '0;
                    acc       = '0;
                    phase     = PP_OFFSET;
                end
                PP_OFFSET:
                begin
                    if (shift_in(b, 8))
                    begin
                        cur_offset = acc;
                        acc        = '0;
                        phase      = PP_ESIZE;
                    end
                end
                PP_ESIZE:
                begin
                    if (shift_in(b, 8))
                    begin
                        sz  = acc;
                        idx = entries_done;
                        acc = '0;
                        if (kind_byte > KIND_MAX || cur_offset > bundle_len ||
                            sz > bundle_len - cur_offset)
                        begin
                            expect_result(STATUS_BAD_ENTRY, 1'b1, idx, 1'b0, cur_offset, sz);
                        end
                        else
                        begin
                            entries_done = idx + 1;
                            phase        = PP_KIND;
                            expect_result(STATUS_ENTRY_OK, entries_done == entries_total, idx,
                                          kind_byte[0], cur_offset, sz);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Called for every accepted output transaction.
        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: status %0d", got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("status", 64'(want.status), 64'(got.status));
            compare("last", 64'(want.last), 64'(got.last));
            compare("entry_index", 64'(want.entry_index), 64'(got.entry_index));
            compare("payload_kind", 64'(want.payload_kind), 64'(got.payload_kind));
            compare("payload_offset", want.payload_offset, got.payload_offset);
            compare("payload_size", want.payload_size, got.payload_size);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        start_req;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic        last;
    logic [31:0] entry_index;
    logic        payload_kind;
    logic [63:0] payload_offset;
    logic [63:0] payload_size;

    manifest_scoreboard board;
    stim_t              stim_q[$];
    logic               cur_order = 1'b0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    bit                 hold_req = 1'b0;
    int                 hold_left = 0;
    int                 quiet_cycles = 0;
    int unsigned        sent_count = 0;

    payload_manifest_validator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .start_req      (start_req),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .last           (last),
        .entry_index    (entry_index),
        .payload_kind   (payload_kind),
        .payload_offset (payload_offset),
        .payload_size   (payload_size)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_upto(logic [63:0] limit);
        if (limit == ALL_ONES)
        begin
            return rand64();
        end
        return rand64() % (limit + 1);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic first);
        stim_t s;
        s.b     = b;
        s.first = first;
        stim_q = {stim_q, s};
    endfunction

    function automatic void push_field(logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
        begin
            push_byte(cur_order ? v[8 * (n - 1 - i) +: 8] : v[8 * i +: 8], 1'b0);
        end
    endfunction

    function automatic void push_header(logic [63:0] msize, logic [63:0] bundle,
                                        logic [31:0] count);
        for (int i = 0; i < 5; i++)
        begin
            push_byte(sig_at(i), i == 0);
        end
        push_field(msize, 8);
        push_field(bundle, 8);
        push_field(64'(count), 4);
    endfunction

    function automatic void push_entry(logic [7:0] kind, logic [63:0] off, logic [63:0] sz);
        push_byte(kind, 1'b0);
        push_field(off, 8);
        push_field(sz, 8);
    endfunction

    function automatic void push_bad_sig(int unsigned plen);
        for (int unsigned i = 0; i < plen; i++)
        begin
            push_byte(sig_at(i), i == 0);
        end
        push_byte(sig_at(plen) ^ (8'h01 << $urandom_range(0, 7)), plen == 0);
    endfunction

    function automatic void gen_manifest();
        int unsigned r;
        int unsigned cut;
        int unsigned n;
        logic [31:0] cnt;
        logic [63:0] meta;
        logic [63:0] bundle;
        logic [63:0] msize;
        logic [63:0] off;
        logic [63:0] rem;
        logic [63:0] sz;
        logic [7:0]  kind;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            push_bad_sig($urandom_range(0, 4));
            return;
        end
        if (r < 20)
        begin
            n = $urandom_range(1, 6);
            for (int unsigned i = 0; i < n; i++)
            begin
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            return;
        end
        case ($urandom_range(0, 9))
            0:       cnt = '0;
            9:       cnt = $urandom;
            default: cnt = $urandom_range(1, 3);
        endcase
        meta = 64'(HDR_BYTES) + 64'(ENTRY_BYTES) * 64'(cnt);
        case ($urandom_range(0, 3))
            0:       bundle = 64'($urandom_range(0, 100));
            1:       bundle = 64'($urandom);
            2:       bundle = rand64() >> $urandom_range(0, 63);
            default: bundle = ALL_ONES - meta;
        endcase
        msize = meta + bundle;
        if ($urandom_range(0, 99) < 15)
        begin
            case ($urandom_range(0, 3))
                0:       msize = msize + 1;
                1:       msize = msize - 1;
                2:       msize = '0;
                default: msize = rand64();
            endcase
        end
        push_header(msize, bundle, cnt);
        n = (cnt > 3) ? 3 : cnt;
        for (int unsigned e = 0; e < n; e++)
        begin
            kind = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, 1))
                                                : 8'($urandom_range(2, 255));
            if ($urandom_range(0, 99) < 85)
            begin
                off = rand_upto(bundle);
            end
            else
            begin
                off = bundle + 1 + $urandom_range(0, 15);
            end
            if (off > bundle)
            begin
                sz = rand64();
            end
            else
            begin
                rem = bundle - off;
                case ($urandom_range(0, 5))
                    0:       sz = rem;
                    1:       sz = rem + 1 + $urandom_range(0, 3);
                    2:       sz = '0;
                    default: sz = rand_upto(rem);
                endcase
            end
            push_entry(kind, off, sz);
        end
        if (r >= 90)
        begin
            cut = $urandom_range(1, stim_q.size() - 1);
            while (stim_q.size() > cut)
            begin
                void'(stim_q.pop_back());
            end
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic first);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        start_req <= first;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        board.note_byte(b, first);
    endtask

    task automatic send_stream();
        stim_t s;
        while (stim_q.size() > 0)
        begin
            s = stim_q.pop_front();
            send_byte(s.b, s.first);
            sent_count++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we           <= 1'b0;
        board.big_endian = v;
        cur_order        = v;
    endtask

    task automatic run_phase(logic order, int s_idle, int r_idle, bit hold);
        int unsigned first_count;
        wait_drained();
        write_order(order);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        if (hold)
        begin
            hold_req = 1'b1;
        end
        first_count = sent_count;
        while (sent_count - first_count < PHASE_BYTES)
        begin
            gen_manifest();
            send_stream();
        end
        // A lone start with a wrong identifier byte leaves the parser idle.
        push_byte(8'h00, 1'b1);
        send_stream();
    endtask

    task automatic run_directed();
        logic [63:0] wide;
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_header(64'd25, '0, '0);
        for (int unsigned p = 0; p < 5; p++)
        begin
            push_bad_sig(p);
        end
        push_header(64'd26, '0, '0);
        push_header('0, '0, 32'd1);
        wide = ALL_ONES - 64'd59;
        push_header(ALL_ONES, wide, 32'd2);
        push_entry(8'd0, wide, '0);
        push_entry(8'd1, '0, wide);
        push_header(64'd142, 64'd100, 32'd1);
        push_entry(8'hFF, '0, '0);
        push_header(64'd142, 64'd100, 32'd1);
        push_entry(8'd2, 64'd100, '0);
        push_header(64'd142, 64'd100, 32'd1);
        push_entry(8'd0, 64'd101, '0);
        push_header(64'd142, 64'd100, 32'd1);
        push_entry(8'd1, 64'd40, 64'd61);
        push_header(64'd25 + 64'd17 * 64'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
        push_entry(8'd1, '0, '0);
        push_entry(8'd0, '0, '0);
        push_header(64'd142, 64'd100, 32'd1);
        repeat (13) void'(stim_q.pop_back());
        for (int i = 0; i < 3; i++)
        begin
            push_byte(sig_at(i), i == 0);
        end
        push_header(64'd42, '0, 32'd1);
        push_entry(8'd1, '0, '0);
        send_stream();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        in_valid  = 1'b0;
        data_byte = '0;
        start_req = 1'b0;
        board     = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 21;
        recv_idle_pct = 76;
        run_directed();
        run_phase(1'b1, 21, 76, 1'b0);
        run_phase(1'b0, 21, 76, 1'b0);
        run_phase(1'b0, 76, 21, 1'b0);
        run_phase(1'b1, 76, 21, 1'b0);
        run_phase(1'b1, 0, 0, 1'b1);
        run_phase(1'b0, 0, 0, 1'b0);
        wait_drained();
        if (board.errors == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                board.check_result({status, last, entry_index, payload_kind,
                                    payload_offset, payload_size});
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

endmodule
